/* rtl/sip_noninvite_client_txn_fsm_assert.svh */
// ----------------------------------------------------------------------------
// SIP non-INVITE client transaction: assertion macros
// Concurrent property wrappers used by the state machine RTL to check itself.
// ----------------------------------------------------------------------------
`ifndef SIP_NONINVITE_CLIENT_TXN_FSM_ASSERT_SVH
`define SIP_NONINVITE_CLIENT_TXN_FSM_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SNCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("snct: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SNCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("snct: next-cycle check failed");

`endif

/* rtl/snct_pkg.sv */
// ----------------------------------------------------------------------------
// SIP non-INVITE client transaction package
// Word types, state encoding, event and command codes, register defaults.
// ----------------------------------------------------------------------------
package snct_pkg;

    localparam int unsigned MS_W   = 24;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register defaults
    localparam logic [MS_W-1:0] T1_RESET      = 24'd500;
    localparam logic [MS_W-1:0] T2_RESET      = 24'd4000;
    localparam logic [MS_W-1:0] TIMER_F_RESET = 24'd32000;
    localparam logic [MS_W-1:0] TIMER_K_RESET = 24'd5000;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_T1      = 2'd0;
    localparam logic [1:0] REG_T2      = 2'd1;
    localparam logic [1:0] REG_TIMER_F = 2'd2;
    localparam logic [1:0] REG_TIMER_K = 2'd3;

    // events
    localparam logic [2:0] EV_SEND       = 3'd0;
    localparam logic [2:0] EV_TIMER_EF   = 3'd1;
    localparam logic [2:0] EV_RESP_1XX   = 3'd2;
    localparam logic [2:0] EV_RESP_FINAL = 3'd3;
    localparam logic [2:0] EV_XPORT_ERR  = 3'd4;
    localparam logic [2:0] EV_TIMER_K    = 3'd5;

    // reported state codes
    localparam logic [2:0] SC_IDLE       = 3'd0;
    localparam logic [2:0] SC_TRYING     = 3'd1;
    localparam logic [2:0] SC_PROCEEDING = 3'd2;
    localparam logic [2:0] SC_COMPLETED  = 3'd3;
    localparam logic [2:0] SC_TERMINATED = 3'd4;

    // timer commands
    localparam logic [1:0] TA_NONE       = 2'd0;
    localparam logic [1:0] TA_START      = 2'd1;
    localparam logic [1:0] TA_STOP       = 2'd2;
    localparam logic [1:0] TA_STOP_START = 2'd3;

    localparam logic [1:0] TS_E = 2'd0;
    localparam logic [1:0] TS_F = 2'd1;
    localparam logic [1:0] TS_K = 2'd2;

    localparam logic [1:0] RS_NONE   = 2'd0;
    localparam logic [1:0] RS_VALID  = 2'd1;
    localparam logic [1:0] RS_IGNORE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_TRYING     = 5'b00010,
        ST_PROCEEDING = 5'b00100,
        ST_COMPLETED  = 5'b01000,
        ST_TERMINATED = 5'b10000
    } t_state;

    typedef struct packed {
        logic [2:0] func;
        logic       over_udp;
    } t_in_word;

    typedef struct packed {
        logic            handled;
        logic [2:0]      new_state;
        logic [1:0]      timer_action;
        logic [1:0]      timer_select;
        logic [MS_W-1:0] timer_duration;
        logic [1:0]      resp_status;
        logic            created;
        logic            terminated_by_resp;
        logic [CNT_W-1:0] retransmit_count;
    } t_out_word;

    typedef struct packed {
        logic [MS_W-1:0] t1_ms;
        logic [MS_W-1:0] t2_ms;
        logic [MS_W-1:0] timer_f_ms;
        logic [MS_W-1:0] timer_k_ms;
    } t_cfg;

    typedef struct packed {
        t_state           fsm_state;
        logic [MS_W-1:0]  elapsed_ms;
        logic [MS_W-1:0]  interval_ms;
        logic [CNT_W-1:0] restarts;
    } t_ctx;

    function automatic logic [2:0] state_code(input t_state s);
        logic [2:0] c;
        case (s)
            ST_IDLE:       c = SC_IDLE;
            ST_TRYING:     c = SC_TRYING;
            ST_PROCEEDING: c = SC_PROCEEDING;
            ST_COMPLETED:  c = SC_COMPLETED;
            ST_TERMINATED: c = SC_TERMINATED;
            default:       c = SC_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/snct_step.sv */
// ----------------------------------------------------------------------------
// SIP non-INVITE client transaction: event step
// Applies one event to the transaction context and builds the result word,
// including the next retransmit interval on a timer E/F expiry.
// ----------------------------------------------------------------------------
module snct_step (
    input  snct_pkg::t_in_word  i_in,
    input  snct_pkg::t_ctx      i_ctx,
    input  snct_pkg::t_cfg      i_cfg,
    output snct_pkg::t_ctx      o_ctx,
    output snct_pkg::t_out_word o_out
);
    import snct_pkg::*;

    logic            w_active;
    logic            w_open;
    logic [MS_W-1:0] w_elapsed;
    logic [MS_W:0]   w_dbl;
    logic [MS_W-1:0] w_capped;
    logic [MS_W-1:0] w_pick;
    logic [MS_W:0]   w_sum;
    logic [MS_W-1:0] w_interval;
    logic            w_expired;

    assign w_active = (i_ctx.fsm_state == ST_TRYING) || (i_ctx.fsm_state == ST_PROCEEDING);
    assign w_open   = w_active || (i_ctx.fsm_state == ST_COMPLETED);

    // first expiry counts the initial T1 interval as spent
    assign w_elapsed = (i_ctx.elapsed_ms == '0) ? i_cfg.t1_ms : i_ctx.elapsed_ms;
    assign w_expired = w_elapsed >= i_cfg.timer_f_ms;

    assign w_dbl    = {i_ctx.interval_ms, 1'b0};
    assign w_capped = (w_dbl > {1'b0, i_cfg.t2_ms}) ? i_cfg.t2_ms : w_dbl[MS_W-1:0];
    assign w_pick   = (i_ctx.fsm_state == ST_TRYING) ? w_capped : i_cfg.t2_ms;
    assign w_sum    = {1'b0, w_elapsed} + {1'b0, w_pick};

    // clip to what is left of the timer F budget
    assign w_interval = (w_sum >= {1'b0, i_cfg.timer_f_ms})
                        ? (i_cfg.timer_f_ms - w_elapsed) : w_pick;

    always_comb begin
        o_ctx = i_ctx;
        o_out = '0;
        case (i_in.func)
            EV_SEND: begin
                if (i_ctx.fsm_state == ST_IDLE) begin
                    o_out.handled      = 1'b1;
                    o_out.created      = 1'b1;
                    o_out.timer_action = TA_START;
                    o_ctx.interval_ms  = i_cfg.t1_ms;
                    o_ctx.elapsed_ms   = '0;
                    o_ctx.restarts     = '0;
                    o_ctx.fsm_state    = ST_TRYING;
                    if (i_in.over_udp) begin
                        o_out.timer_select   = TS_E;
                        o_out.timer_duration = i_cfg.t1_ms;
                    end else begin
                        o_out.timer_select   = TS_F;
                        o_out.timer_duration = i_cfg.timer_f_ms;
                    end
                end
            end
            EV_TIMER_EF: begin
                if (w_active) begin
                    o_out.handled    = 1'b1;
                    o_ctx.elapsed_ms = w_elapsed;
                    if (!i_in.over_udp || w_expired) begin
                        o_ctx.fsm_state = ST_TERMINATED;
                    end else if (w_interval != '0) begin
                        o_out.timer_action   = TA_START;
                        o_out.timer_select   = TS_E;
                        o_out.timer_duration = w_interval;
                        if (i_ctx.restarts != '1) begin
                            o_ctx.restarts = i_ctx.restarts + 1'b1;
                        end
                        o_ctx.elapsed_ms  = w_elapsed + w_interval;
                        o_ctx.interval_ms = w_interval;
                    end
                end
            end
            EV_RESP_1XX: begin
                if (w_open) begin
                    o_out.handled = 1'b1;
                    if (i_ctx.fsm_state == ST_COMPLETED) begin
                        o_out.resp_status = RS_IGNORE;
                    end else begin
                        o_out.resp_status = RS_VALID;
                        o_ctx.fsm_state   = ST_PROCEEDING;
                    end
                end
            end
            EV_RESP_FINAL: begin
                if (w_open) begin
                    o_out.handled = 1'b1;
                    if (i_ctx.fsm_state == ST_COMPLETED) begin
                        o_out.resp_status = RS_IGNORE;
                    end else if (i_in.over_udp) begin
                        o_out.resp_status    = RS_VALID;
                        o_out.timer_action   = TA_STOP_START;
                        o_out.timer_select   = TS_K;
                        o_out.timer_duration = i_cfg.timer_k_ms;
                        o_ctx.interval_ms    = i_cfg.timer_k_ms;
                        o_ctx.fsm_state      = ST_COMPLETED;
                    end else begin
                        o_out.resp_status        = RS_VALID;
                        o_out.timer_action       = TA_STOP;
                        o_out.terminated_by_resp = 1'b1;
                        o_ctx.fsm_state          = ST_TERMINATED;
                    end
                end
            end
            EV_XPORT_ERR: begin
                if (w_open) begin
                    o_out.handled      = 1'b1;
                    o_out.timer_action = TA_STOP;
                    o_ctx.fsm_state    = ST_TERMINATED;
                end
            end
            EV_TIMER_K: begin
                if (i_ctx.fsm_state == ST_COMPLETED) begin
                    o_out.handled   = 1'b1;
                    o_ctx.fsm_state = ST_TERMINATED;
                end
            end
            default: begin
            end
        endcase
        o_out.new_state        = state_code(o_ctx.fsm_state);
        o_out.retransmit_count = o_ctx.restarts;
    end

endmodule

/* rtl/sip_noninvite_client_txn_fsm.sv */
// An accepted word goes to the input register, then to the result register on o_out.
// Throughput: one event word per cycle while results drain; one-step context loop.
// Backpressure: the input stage holds while the result register is full and not taken.
// Reset (i_rst_n low, synchronous): state idle, timers and count zero, registers at defaults.
// ----------------------------------------------------------------------------
// SIP non-INVITE client transaction state machine
// Input register, one step of event logic, result register; APB register file.
// ----------------------------------------------------------------------------
`include "sip_noninvite_client_txn_fsm_assert.svh"

module sip_noninvite_client_txn_fsm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  snct_pkg::t_in_word               i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output snct_pkg::t_out_word              o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [snct_pkg::ADDR_W-1:0]      paddr,
    input  logic [snct_pkg::DATA_W-1:0]      pwdata,
    output logic [snct_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import snct_pkg::*;

    t_cfg      r_cfg;
    t_ctx      r_ctx;
    t_ctx      n_ctx;
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      w_adv;
    logic      w_take;
    logic      w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.t1_ms      <= T1_RESET;
            r_cfg.t2_ms      <= T2_RESET;
            r_cfg.timer_f_ms <= TIMER_F_RESET;
            r_cfg.timer_k_ms <= TIMER_K_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_T1:      r_cfg.t1_ms      <= pwdata[MS_W-1:0];
                REG_T2:      r_cfg.t2_ms      <= pwdata[MS_W-1:0];
                REG_TIMER_F: r_cfg.timer_f_ms <= pwdata[MS_W-1:0];
                REG_TIMER_K: r_cfg.timer_k_ms <= pwdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_T1:      prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.t1_ms};
            REG_T2:      prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.t2_ms};
            REG_TIMER_F: prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.timer_f_ms};
            REG_TIMER_K: prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.timer_k_ms};
            default:     prdata = '0;
        endcase
    end

    // advance the held word once the result slot is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    snct_step u_step (
        .i_in  (r_in),
        .i_ctx (r_ctx),
        .i_cfg (r_cfg),
        .o_ctx (n_ctx),
        .o_out (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx.fsm_state   <= ST_IDLE;
            r_ctx.elapsed_ms  <= '0;
            r_ctx.interval_ms <= '0;
            r_ctx.restarts    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_ctx       <= n_ctx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SNCT_ASSERT_NEXT(a_term_sticks, i_clk, i_rst_n,
        r_ctx.fsm_state == ST_TERMINATED, r_ctx.fsm_state == ST_TERMINATED)
    `SNCT_ASSERT_NOW(a_idle_timer, i_clk, i_rst_n,
        o_out_valid && (o_out.timer_action == TA_NONE || o_out.timer_action == TA_STOP),
        o_out.timer_select == TS_E && o_out.timer_duration == '0)
    `SNCT_ASSERT_NOW(a_unhandled_quiet, i_clk, i_rst_n,
        o_out_valid && !o_out.handled,
        o_out.timer_action == TA_NONE && o_out.resp_status == RS_NONE && !o_out.created)
    `SNCT_ASSERT_NOW(a_create_fresh, i_clk, i_rst_n,
        o_out_valid && o_out.created,
        o_out.new_state == SC_TRYING && o_out.retransmit_count == '0)

endmodule

/* tb/tb_sip_noninvite_client_txn_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIP non-INVITE client transaction testbench
// Drives one transaction from idle to terminated with directed and random
// event words, retunes the timer registers between phases over APB, and
// checks every result word against a cycle-free transaction tracker.
// ----------------------------------------------------------------------------
module tb_sip_noninvite_client_txn_fsm;
    import snct_pkg::*;

    localparam logic [2:0]      EV_INVALID  = 3'd6;
    localparam logic [2:0]      EV_RESERVED = 3'd7;
    localparam logic [MS_W-1:0] MS_MAX      = '1;
    localparam int unsigned     MAX_SHOWN   = 20;

    class txn_tracker;
        logic [MS_W-1:0]  t1, t2, tf, tk;
        logic [2:0]       st;
        logic [MS_W-1:0]  elapsed, interval;
        logic [CNT_W-1:0] restarts;
        t_out_word        due_results[$];
        int unsigned      n_events, n_handled, n_checked, errors;

        function new();
            t1 = T1_RESET;
            t2 = T2_RESET;
            tf = TIMER_F_RESET;
            tk = TIMER_K_RESET;
            st = SC_IDLE;
            elapsed = '0;
            interval = '0;
            restarts = '0;
            n_events = 0;
            n_handled = 0;
            n_checked = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [MS_W-1:0] v);
            case (idx)
                REG_T1:      t1 = v;
                REG_T2:      t2 = v;
                REG_TIMER_F: tf = v;
                REG_TIMER_K: tk = v;
                default: ;
            endcase
        endfunction

        function void take_event(t_in_word w);
            t_out_word     r;
            logic [MS_W:0] step;
            logic          active;
            r = '0;
            step = '0;
            active = (st == SC_TRYING) || (st == SC_PROCEEDING);
            case (w.func)
                EV_SEND: if (st == SC_IDLE) begin
                    r.handled = 1'b1;
                    r.created = 1'b1;
                    r.timer_action = TA_START;
                    r.timer_select = w.over_udp ? TS_E : TS_F;
                    r.timer_duration = w.over_udp ? t1 : tf;
                    interval = t1;
                    elapsed = '0;
                    restarts = '0;
                    st = SC_TRYING;
                end
                EV_TIMER_EF: if (active) begin
                    r.handled = 1'b1;
                    if (elapsed == '0) elapsed = t1;
                    if (!w.over_udp || elapsed >= tf) begin
                        st = SC_TERMINATED;
                    end else begin
                        // double in trying, jump straight to T2 in proceeding
                        if (st == SC_TRYING) step = {interval, 1'b0};
                        else step = {1'b0, t2};
                        if (step > {1'b0, t2}) step = {1'b0, t2};
                        // clip to what is left of the Timer F budget
                        if ({1'b0, elapsed} + step >= {1'b0, tf}) step = {1'b0, tf - elapsed};
                        if (step != '0) begin
                            r.timer_action = TA_START;
                            r.timer_select = TS_E;
                            r.timer_duration = step[MS_W-1:0];
                            if (restarts != '1) restarts = restarts + 1'b1;
                            elapsed = elapsed + step[MS_W-1:0];
                            interval = step[MS_W-1:0];
                        end
                    end
                end
                EV_RESP_1XX: if (active || st == SC_COMPLETED) begin
                    r.handled = 1'b1;
                    if (st == SC_COMPLETED) begin
                        r.resp_status = RS_IGNORE;
                    end else begin
                        r.resp_status = RS_VALID;
                        st = SC_PROCEEDING;
                    end
                end
                EV_RESP_FINAL: if (active || st == SC_COMPLETED) begin
                    r.handled = 1'b1;
                    if (st == SC_COMPLETED) begin
                        r.resp_status = RS_IGNORE;
                    end else if (w.over_udp) begin
                        r.resp_status = RS_VALID;
                        r.timer_action = TA_STOP_START;
                        r.timer_select = TS_K;
                        r.timer_duration = tk;
                        interval = tk;
                        st = SC_COMPLETED;
                    end else begin
                        r.resp_status = RS_VALID;
                        r.timer_action = TA_STOP;
                        r.terminated_by_resp = 1'b1;
                        st = SC_TERMINATED;
                    end
                end
                EV_XPORT_ERR: if (active || st == SC_COMPLETED) begin
                    r.handled = 1'b1;
                    r.timer_action = TA_STOP;
                    st = SC_TERMINATED;
                end
                EV_TIMER_K: if (st == SC_COMPLETED) begin
                    r.handled = 1'b1;
                    st = SC_TERMINATED;
                end
                default: ;
            endcase
            r.new_state = st;
            r.retransmit_count = restarts;
            due_results.push_back(r);
            n_events++;
            if (r.handled) n_handled++;
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("ERROR word %0d %s: got %0h, expected %0h", n_checked, what, got, want);
        endtask

        task match_result(t_out_word got);
            t_out_word want;
            n_checked++;
            if (due_results.size() == 0) begin
                report("arrived with nothing expected", 48'(got), '0);
            end else begin
                want = due_results.pop_front();
                if (got.handled !== want.handled)
                    report("handled", 48'(got.handled), 48'(want.handled));
                if (got.new_state !== want.new_state)
                    report("new_state", 48'(got.new_state), 48'(want.new_state));
                if (got.timer_action !== want.timer_action)
                    report("timer_action", 48'(got.timer_action), 48'(want.timer_action));
                if (got.timer_select !== want.timer_select)
                    report("timer_select", 48'(got.timer_select), 48'(want.timer_select));
                if (got.timer_duration !== want.timer_duration)
                    report("timer_duration", 48'(got.timer_duration),
                           48'(want.timer_duration));
                if (got.resp_status !== want.resp_status)
                    report("resp_status", 48'(got.resp_status), 48'(want.resp_status));
                if (got.created !== want.created)
                    report("created", 48'(got.created), 48'(want.created));
                if (got.terminated_by_resp !== want.terminated_by_resp)
                    report("terminated_by_resp", 48'(got.terminated_by_resp),
                           48'(want.terminated_by_resp));
                if (got.retransmit_count !== want.retransmit_count)
                    report("retransmit_count", 48'(got.retransmit_count),
                           48'(want.retransmit_count));
            end
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_word         o_out;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    txn_tracker  tracker   = new();
    bit          calm      = 1'b0;
    int unsigned long_hold = 0;
    int unsigned n_writes  = 0;

    sip_noninvite_client_txn_fsm u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // extreme low, extreme high, or anything in between
    function automatic logic [MS_W-1:0] pick_ms(input logic [MS_W-1:0] lo);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return MS_MAX;
            default: return MS_W'($urandom_range(32'(lo), 32'(MS_MAX)));
        endcase
    endfunction

    task automatic fire(input logic [2:0] func, input logic udp);
        t_in_word    w;
        int unsigned gap;
        w.func = func;
        w.over_udp = udp;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_event(w);
    endtask

    // hold the input until every result word is back, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [MS_W-1:0] value);
        paddr <= {idx, 2'b00};
        pwdata <= {{(DATA_W-MS_W){1'b0}}, value};
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(idx, value);
        n_writes++;
        // read back through a second transfer on the same address
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(DATA_W-MS_W){1'b0}}, value})
            tracker.report("register readback", 48'(prdata), 48'(value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic retune(input logic [MS_W-1:0] t1v, t2v, tfv, tkv);
        drain();
        program_reg(REG_T1, t1v);
        program_reg(REG_T2, t2v);
        program_reg(REG_TIMER_F, tfv);
        program_reg(REG_TIMER_K, tkv);
    endtask

    initial begin : result_sink
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            if (long_hold != 0) begin
                stall = long_hold;
                long_hold = 0;
            end else begin
                stall = draw_wait();
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            tracker.match_result(o_out);
        end
    end

    initial begin : stimulus
        int unsigned     seg;
        int unsigned     base;
        int unsigned     roll;
        int unsigned     tries;
        int              ending;
        logic [2:0]      noise;
        logic [MS_W-1:0] budget;
        string           closed_by;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle takes nothing but a send: others at max, two also at min
        retune(MS_MAX, MS_MAX, MS_MAX, MS_MAX);
        fire(EV_TIMER_EF, 1'b1);
        fire(EV_RESP_1XX, 1'b0);
        fire(EV_RESP_FINAL, 1'b1);
        fire(EV_XPORT_ERR, 1'b0);
        fire(EV_TIMER_K, 1'b1);
        fire(EV_INVALID, 1'b0);
        fire(EV_RESERVED, 1'b1);
        retune(24'd1, 24'd1, 24'd1, '0);
        fire(EV_RESP_FINAL, 1'b0);
        fire(EV_TIMER_EF, 1'b0);

        // open the transaction with a small T2 so the budget lasts
        retune(MS_W'($urandom_range(1, 4)), MS_W'($urandom_range(8, 64)), MS_MAX,
               pick_ms('0));
        fire(EV_SEND, 1'($urandom_range(0, 1)));
        fire(EV_SEND, 1'b1);
        fire(EV_TIMER_K, 1'b0);
        fire(EV_RESERVED, 1'b0);
        repeat (3) fire(EV_TIMER_EF, 1'b1);
        fire(EV_RESP_1XX, 1'b1);
        repeat (2) fire(EV_TIMER_EF, 1'b1);
        fire(EV_RESP_1XX, 1'b0);
        fire(EV_SEND, 1'b0);

        // keep the transaction alive: retransmits and provisional responses,
        // with ignored events mixed in
        for (seg = 0; seg < 8; seg++) begin
            calm = ($urandom_range(0, 3) == 0);
            if (seg % 2 == 1)
                retune(pick_ms(24'd1), MS_W'($urandom_range(1, 64)),
                       MS_W'($urandom_range(32'(MS_MAX), 32'(tracker.elapsed) + 200000)),
                       pick_ms('0));
            if (seg == 2) begin
                // flood the input while the output side stalls
                calm = 1'b1;
                long_hold = $urandom_range(40, 60);
            end
            base = tracker.n_handled;
            while (tracker.n_handled - base < 40) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    fire(EV_TIMER_EF, 1'b1);
                end else if (roll < 75) begin
                    fire(EV_RESP_1XX, 1'($urandom_range(0, 1)));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       noise = EV_SEND;
                        1:       noise = EV_TIMER_K;
                        2:       noise = EV_INVALID;
                        default: noise = EV_RESERVED;
                    endcase
                    fire(noise, 1'($urandom_range(0, 1)));
                end
            end
        end

        calm = 1'b0;
        ending = $urandom_range(0, 5);
        case (ending)
            0, 1: begin
                retune(pick_ms(24'd1), pick_ms(24'd1), tracker.tf, pick_ms('0));
                fire(EV_RESP_FINAL, 1'b1);
                fire(EV_RESP_1XX, 1'($urandom_range(0, 1)));
                fire(EV_RESP_FINAL, 1'($urandom_range(0, 1)));
                fire(EV_TIMER_EF, 1'b1);
                fire(EV_SEND, 1'($urandom_range(0, 1)));
                if (ending == 0) begin
                    fire(EV_TIMER_K, 1'($urandom_range(0, 1)));
                    closed_by = "timer K in completed";
                end else begin
                    fire(EV_XPORT_ERR, 1'($urandom_range(0, 1)));
                    closed_by = "transport error in completed";
                end
            end
            2: begin
                fire(EV_RESP_FINAL, 1'b0);
                closed_by = "final response over reliable transport";
            end
            3: begin
                fire(EV_TIMER_EF, 1'b0);
                closed_by = "timeout over reliable transport";
            end
            4: begin
                // leave a short budget and let a huge T2 run it out
                budget = tracker.elapsed + MS_W'($urandom_range(1, 100000));
                retune(tracker.t1, MS_MAX, budget, tracker.tk);
                tries = 0;
                while (tracker.st != SC_TERMINATED && tries < 40) begin
                    fire(EV_TIMER_EF, 1'b1);
                    tries++;
                end
                closed_by = "exhausted Timer F budget";
            end
            default: begin
                fire(EV_XPORT_ERR, 1'($urandom_range(0, 1)));
                closed_by = "transport error while active";
            end
        endcase

        // terminated ignores everything
        retune(pick_ms(24'd1), pick_ms(24'd1), pick_ms(24'd1), pick_ms('0));
        repeat (40) fire(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));

        drain();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d event words (%0d handled), %0d result words, %0d register writes.",
                 tracker.n_events, tracker.n_handled, tracker.n_checked, n_writes);
        $display("Transaction ended by %s after %0d timer E restarts, with output stall and drains.",
                 closed_by, tracker.restarts);
        if (tracker.errors == 0) begin
            $display("sip_noninvite_client_txn_fsm test passed");
        end else begin
            $display("sip_noninvite_client_txn_fsm test failed");
        end
        $finish;
    end

    // well beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("sip_noninvite_client_txn_fsm test failed");
        $finish;
    end

endmodule
